>>> hdl/fqea_pkg.sv
// Shared types, constants and helpers for the four-quadrant energy accumulator.
package fqea_pkg;

  localparam int TariffSlotsDef = 4;
  localparam int PhaseSlotsDef  = 3;

  // Energy is power (32 bits magnitude) times a 16-bit time step.
  localparam int EnergyW = 48;
  localparam int TotalW  = 63;
  localparam logic [TotalW-1:0] TotalMax = {TotalW{1'b1}};

  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 3;
  localparam logic [CfgIdxW-1:0] CfgPhases  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgTariffs = 1'b1;

  localparam logic [1:0] PhasesReset  = 2'd3;
  localparam logic [2:0] TariffsReset = 3'd4;

  localparam int QueueDepth = 2;

  typedef enum logic [1:0] {
    QUAD_1 = 2'd0,
    QUAD_2 = 2'd1,
    QUAD_3 = 2'd2,
    QUAD_4 = 2'd3
  } quad_e;

  typedef struct packed {
    logic  rejected;
    logic  import_side;
    quad_e quad;
  } ctl_t;

  // Saturating add; bit TotalW of the result flags a clip.
  function automatic logic [TotalW:0] sat_add(input logic [TotalW-1:0] cur,
                                              input logic [EnergyW-1:0] amt);
    logic [TotalW:0] sum;
    sum = {1'b0, cur} + (TotalW + 1)'(amt);
    if (sum[TotalW]) begin
      return {1'b1, TotalMax};
    end
    return {1'b0, sum[TotalW-1:0]};
  endfunction

endpackage

>>> hdl/fqea_front.sv
// Front end: count registers, range check, quadrant classification and energy products.
module fqea_front #(
  parameter int TARIFF_SLOTS = fqea_pkg::TariffSlotsDef,
  parameter int PHASE_SLOTS  = fqea_pkg::PhaseSlotsDef,
  parameter int SLOT_W       = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [fqea_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [fqea_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic [1:0]                        phase_i,
  input  logic [1:0]                        tariff_i,
  input  logic [15:0]                       time_step_i,
  input  logic signed [31:0]                active_power_i,
  input  logic signed [31:0]                reactive_power_i,
  input  logic [30:0]                       apparent_power_i,
  output fqea_pkg::ctl_t                    ctl_o,
  output logic [SLOT_W-1:0]                 slot_o,
  output logic [fqea_pkg::EnergyW-1:0]      active_energy_o,
  output logic [fqea_pkg::EnergyW-1:0]      reactive_energy_o,
  output logic [fqea_pkg::EnergyW-1:0]      apparent_energy_o
);

  logic [1:0]  phases_q;
  logic [2:0]  tariffs_q;
  logic [31:0] a_mag;
  logic [31:0] r_mag;
  logic        a_neg;
  logic        r_neg;
  logic        reject;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phases_q  <= fqea_pkg::PhasesReset;
      tariffs_q <= fqea_pkg::TariffsReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        fqea_pkg::CfgPhases:  phases_q  <= cfg_data_i[1:0];
        fqea_pkg::CfgTariffs: tariffs_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign reject = (phase_i >= phases_q) || ({1'b0, tariff_i} >= tariffs_q) ||
                  (32'(phase_i) >= 32'(PHASE_SLOTS)) ||
                  (32'(tariff_i) >= 32'(TARIFF_SLOTS));

  assign a_mag = active_power_i[31] ? 32'(-active_power_i) : active_power_i;
  assign r_mag = reactive_power_i[31] ? 32'(-reactive_power_i) : reactive_power_i;

  // A negative power over a zero time step is zero energy, which counts as nonnegative.
  assign a_neg = active_power_i[31] && (time_step_i != 16'd0);
  assign r_neg = reactive_power_i[31] && (time_step_i != 16'd0);

  always_comb begin
    ctl_o.rejected    = reject;
    ctl_o.import_side = !reject && !a_neg;
    if (reject) begin
      ctl_o.quad = fqea_pkg::QUAD_1;
    end else if (!a_neg && !r_neg) begin
      ctl_o.quad = fqea_pkg::QUAD_1;
    end else if (a_neg && !r_neg) begin
      ctl_o.quad = fqea_pkg::QUAD_2;
    end else if (a_neg) begin
      ctl_o.quad = fqea_pkg::QUAD_3;
    end else begin
      ctl_o.quad = fqea_pkg::QUAD_4;
    end
  end

  // Park rejected items on slot zero so that no read goes past the stores.
  assign slot_o = reject ? '0 :
                  SLOT_W'(SLOT_W'(tariff_i) * SLOT_W'(PHASE_SLOTS) + SLOT_W'(phase_i));

  assign active_energy_o   = fqea_pkg::EnergyW'(a_mag) * fqea_pkg::EnergyW'(time_step_i);
  assign reactive_energy_o = fqea_pkg::EnergyW'(r_mag) * fqea_pkg::EnergyW'(time_step_i);
  assign apparent_energy_o = fqea_pkg::EnergyW'(apparent_power_i) *
                             fqea_pkg::EnergyW'(time_step_i);

endmodule

>>> hdl/fqea_queue.sv
// Two-entry queue between the front end and the accumulate stage.
module fqea_queue #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  logic [W-1:0] push_data_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output logic [W-1:0] pop_data_o
);

  localparam int PtrW = $clog2(fqea_pkg::QueueDepth);
  localparam int CntW = $clog2(fqea_pkg::QueueDepth + 1);

  logic [W-1:0]    entry_q [fqea_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push;
  logic            pop;

  assign push_ready_o = (count_q != CntW'(fqea_pkg::QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(fqea_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(fqea_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> hdl/fqea_back.sv
// Back end: energy stores, saturating read-modify-write with forwarding, result register.
module fqea_back #(
  parameter int SLOTS  = 12,
  parameter int SLOT_W = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  output logic                          q_ready_o,
  input  fqea_pkg::ctl_t                q_ctl_i,
  input  logic [SLOT_W-1:0]             q_slot_i,
  input  logic [fqea_pkg::EnergyW-1:0]  q_active_i,
  input  logic [fqea_pkg::EnergyW-1:0]  q_reactive_i,
  input  logic [fqea_pkg::EnergyW-1:0]  q_apparent_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [fqea_pkg::TotalW-1:0]   active_total_o,
  output logic [fqea_pkg::TotalW-1:0]   apparent_total_o,
  output logic [fqea_pkg::TotalW-1:0]   reactive_total_o,
  output fqea_pkg::ctl_t                out_ctl_o,
  output logic                          saturated_o
);

  localparam int SideDepth = 2 * SLOTS;
  localparam int QuadDepth = 4 * SLOTS;
  localparam int SideW     = SLOT_W + 1;
  localparam int QuadW     = SLOT_W + 2;
  localparam int TW        = fqea_pkg::TotalW;
  localparam int EW        = fqea_pkg::EnergyW;

  // Active and apparent share addressing: one slot, plus or minus side.
  logic [TW-1:0]        act_mem_q [SideDepth];
  logic [TW-1:0]        app_mem_q [SideDepth];
  logic [TW-1:0]        rea_mem_q [QuadDepth];
  logic [SideDepth-1:0] side_vld_q;
  logic [QuadDepth-1:0] quad_vld_q;

  logic                 a_valid_q;
  fqea_pkg::ctl_t       a_ctl_q;
  logic [SideW-1:0]     a_side_addr_q;
  logic [QuadW-1:0]     a_quad_addr_q;
  logic [EW-1:0]        a_act_e_q, a_rea_e_q, a_app_e_q;
  logic [TW-1:0]        rd_act_q, rd_app_q, rd_rea_q;
  logic                 rd_side_vld_q, rd_quad_vld_q;

  // Last write to each store, to cover the read issued on the same edge.
  logic                 lw_side_v_q, lw_quad_v_q;
  logic [SideW-1:0]     lw_side_addr_q;
  logic [QuadW-1:0]     lw_quad_addr_q;
  logic [TW-1:0]        lw_act_q, lw_app_q, lw_rea_q;

  logic                 out_valid_q;
  logic [TW-1:0]        out_act_q, out_app_q, out_rea_q;
  fqea_pkg::ctl_t       out_ctl_q;
  logic                 out_sat_q;

  logic                 a_go, a_ready, a_load, a_write;
  logic [SideW-1:0]     side_addr;
  logic [QuadW-1:0]     quad_addr;
  logic [TW-1:0]        cur_act, cur_app, cur_rea;
  logic [TW:0]          new_act, new_app, new_rea;

  assign a_go      = a_valid_q && (!out_valid_q || out_ready_i);
  assign a_ready   = !a_valid_q || a_go;
  assign a_load    = q_valid_i && a_ready;
  assign q_ready_o = a_ready;
  assign a_write   = a_go && !a_ctl_q.rejected;

  assign side_addr = {q_slot_i, !q_ctl_i.import_side};
  assign quad_addr = {q_slot_i, q_ctl_i.quad};

  always_comb begin
    if (lw_side_v_q && (lw_side_addr_q == a_side_addr_q)) begin
      cur_act = lw_act_q;
      cur_app = lw_app_q;
    end else begin
      cur_act = rd_side_vld_q ? rd_act_q : '0;
      cur_app = rd_side_vld_q ? rd_app_q : '0;
    end
    if (lw_quad_v_q && (lw_quad_addr_q == a_quad_addr_q)) begin
      cur_rea = lw_rea_q;
    end else begin
      cur_rea = rd_quad_vld_q ? rd_rea_q : '0;
    end
  end

  assign new_act = fqea_pkg::sat_add(cur_act, a_act_e_q);
  assign new_app = fqea_pkg::sat_add(cur_app, a_app_e_q);
  assign new_rea = fqea_pkg::sat_add(cur_rea, a_rea_e_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      lw_side_v_q <= 1'b0;
      lw_quad_v_q <= 1'b0;
      side_vld_q  <= '0;
      quad_vld_q  <= '0;
    end else begin
      if (a_load) begin
        a_valid_q <= 1'b1;
      end else if (a_go) begin
        a_valid_q <= 1'b0;
      end
      if (a_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (a_write) begin
        lw_side_v_q               <= 1'b1;
        lw_quad_v_q               <= 1'b1;
        side_vld_q[a_side_addr_q] <= 1'b1;
        quad_vld_q[a_quad_addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_load) begin
      a_ctl_q       <= q_ctl_i;
      a_side_addr_q <= side_addr;
      a_quad_addr_q <= quad_addr;
      a_act_e_q     <= q_active_i;
      a_rea_e_q     <= q_reactive_i;
      a_app_e_q     <= q_apparent_i;
      rd_act_q      <= act_mem_q[side_addr];
      rd_app_q      <= app_mem_q[side_addr];
      rd_rea_q      <= rea_mem_q[quad_addr];
      rd_side_vld_q <= side_vld_q[side_addr];
      rd_quad_vld_q <= quad_vld_q[quad_addr];
    end
    if (a_write) begin
      act_mem_q[a_side_addr_q] <= new_act[TW-1:0];
      app_mem_q[a_side_addr_q] <= new_app[TW-1:0];
      rea_mem_q[a_quad_addr_q] <= new_rea[TW-1:0];
      lw_side_addr_q           <= a_side_addr_q;
      lw_quad_addr_q           <= a_quad_addr_q;
      lw_act_q                 <= new_act[TW-1:0];
      lw_app_q                 <= new_app[TW-1:0];
      lw_rea_q                 <= new_rea[TW-1:0];
    end
    if (a_go) begin
      out_ctl_q <= a_ctl_q;
      if (a_ctl_q.rejected) begin
        out_act_q <= '0;
        out_app_q <= '0;
        out_rea_q <= '0;
        out_sat_q <= 1'b0;
      end else begin
        out_act_q <= new_act[TW-1:0];
        out_app_q <= new_app[TW-1:0];
        out_rea_q <= new_rea[TW-1:0];
        out_sat_q <= new_act[TW] || new_app[TW] || new_rea[TW];
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign active_total_o   = out_act_q;
  assign apparent_total_o = out_app_q;
  assign reactive_total_o = out_rea_q;
  assign out_ctl_o        = out_ctl_q;
  assign saturated_o      = out_sat_q;

endmodule

>>> hdl/four_quadrant_energy_accumulator.sv
// Four-quadrant energy accumulator: front end, queue and accumulate stage.
//
// Takes one power sample per cycle unless the result stream stalls, and
// returns one result per sample, in order. A sample passes the front end
// (range check, quadrant, three power-by-time-step products) into a
// two-entry queue on the accepting edge; the accumulate stage then reads
// the energy stores, and the result register takes the updated totals.
// Sustained rate is one item per cycle unless the result stream stalls,
// set by the single read-modify-write per store, whose registered read is
// completed by forwarding the last write. Totals clip at 2^63-1. Stores
// read as zero after reset through per-entry valid bits, so there is no
// clearing pass. cfg_ready_o is always high; write the count registers
// only while no item is in flight.
module four_quadrant_energy_accumulator #(
  parameter int TARIFF_SLOTS = fqea_pkg::TariffSlotsDef,
  parameter int PHASE_SLOTS  = fqea_pkg::PhaseSlotsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fqea_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [fqea_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // time_step[15:0], active_power[47:16], reactive_power[79:48], apparent_power[110:80]
  input  logic [111:0]                  s_axis_tdata,
  // phase[1:0], tariff[3:2]
  input  logic [3:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // active_total[62:0], apparent_total[125:63], reactive_total[188:126]
  output logic [191:0]                  m_axis_tdata,
  // quadrant[1:0], import_side[2], saturated[3], rejected[4]
  output logic [4:0]                    m_axis_tuser
);

  localparam int Slots  = TARIFF_SLOTS * PHASE_SLOTS;
  localparam int SlotW  = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int EW     = fqea_pkg::EnergyW;
  localparam int CtlW   = $bits(fqea_pkg::ctl_t);
  localparam int QW     = CtlW + SlotW + 3 * EW;

  fqea_pkg::ctl_t             f_ctl, q_ctl, out_ctl;
  logic [SlotW-1:0]           f_slot, q_slot;
  logic [EW-1:0]              f_act, f_rea, f_app;
  logic [EW-1:0]              q_act, q_rea, q_app;
  logic [QW-1:0]              q_data;
  logic                       q_valid, q_ready;
  logic [fqea_pkg::TotalW-1:0] act_total, app_total, rea_total;
  logic                       saturated;

  assign cfg_ready_o = 1'b1;

  fqea_front #(
    .TARIFF_SLOTS (TARIFF_SLOTS),
    .PHASE_SLOTS  (PHASE_SLOTS),
    .SLOT_W       (SlotW)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .phase_i           (s_axis_tuser[1:0]),
    .tariff_i          (s_axis_tuser[3:2]),
    .time_step_i       (s_axis_tdata[15:0]),
    .active_power_i    (s_axis_tdata[47:16]),
    .reactive_power_i  (s_axis_tdata[79:48]),
    .apparent_power_i  (s_axis_tdata[110:80]),
    .ctl_o             (f_ctl),
    .slot_o            (f_slot),
    .active_energy_o   (f_act),
    .reactive_energy_o (f_rea),
    .apparent_energy_o (f_app)
  );

  fqea_queue #(
    .W (QW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (s_axis_tvalid),
    .push_ready_o (s_axis_tready),
    .push_data_i  ({f_ctl, f_slot, f_act, f_rea, f_app}),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_data)
  );

  assign {q_ctl, q_slot, q_act, q_rea, q_app} = q_data;

  fqea_back #(
    .SLOTS  (Slots),
    .SLOT_W (SlotW)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_ready_o        (q_ready),
    .q_ctl_i          (q_ctl),
    .q_slot_i         (q_slot),
    .q_active_i       (q_act),
    .q_reactive_i     (q_rea),
    .q_apparent_i     (q_app),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .active_total_o   (act_total),
    .apparent_total_o (app_total),
    .reactive_total_o (rea_total),
    .out_ctl_o        (out_ctl),
    .saturated_o      (saturated)
  );

  assign m_axis_tdata = {3'b000, rea_total, app_total, act_total};
  assign m_axis_tuser = {out_ctl.rejected, saturated, out_ctl.import_side, out_ctl.quad};

endmodule

>>> hdl/fqea_checker.sv
// Port-level checks on the result stream of the energy accumulator, bound to the top level.
module fqea_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [191:0] m_axis_tdata,
  input logic [4:0]   m_axis_tuser
);

  localparam logic [62:0] Max = {63{1'b1}};

  // A rejected item carries nothing but the reject flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[4] |-> (m_axis_tdata == '0) && (m_axis_tuser[3:0] == '0))
    else $error("rejected item carries data");

  // Plus side pairs with Q1 or Q4, minus side with Q2 or Q3.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[4] |->
      (m_axis_tuser[2] == ((m_axis_tuser[1:0] == 2'd0) || (m_axis_tuser[1:0] == 2'd3))))
    else $error("quadrant does not match import side");

  // A clip leaves at least one total pinned at full scale.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[3] |->
      (m_axis_tdata[62:0] == Max) || (m_axis_tdata[125:63] == Max) ||
      (m_axis_tdata[188:126] == Max))
    else $error("saturated flag without a clipped total");

  // Hold a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind four_quadrant_energy_accumulator fqea_checker u_fqea_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
